// ===== src/grid_raycast_column_defines.svh =====
// Assertion macros shared by the ray caster checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define GRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/grc_pkg.sv =====
// Shared types, constants and codes of the grid ray caster.
// No dependencies; files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

    // Geometry and limits
    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 384;
    localparam int MAP_SIZE      = 32;
    localparam int MAX_STEPS     = 64;

    localparam int FRAC       = 16;
    localparam int MAP_BITS   = 5;
    localparam int MAP_DEPTH  = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W     = 2 * MAP_BITS;
    // camera x = col * 2^(FRAC+1) / SCREEN_WIDTH - 1.0, width is a power of two
    localparam int CAMX_SHIFT = FRAC + 1 - $clog2(SCREEN_WIDTH);
    localparam int HALF_H     = SCREEN_HEIGHT / 2;
    localparam int ROW_MAX    = SCREEN_HEIGHT - 1;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int DIV_W      = 40;
    localparam int DIVISOR_W  = 24;
    localparam int DIST_W     = 24;
    localparam int LH_W       = 25;
    localparam int CFG_W      = 21;

    // Input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_POS_X,
        CFG_POS_Y,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_PLANE_X,
        CFG_PLANE_Y
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [20:0]        POS_X_RST   = 21'd98304;
    localparam logic [20:0]        POS_Y_RST   = 21'd98304;
    localparam logic signed [17:0] DIR_X_RST   = -18'sd65536;
    localparam logic signed [17:0] DIR_Y_RST   = 18'sd0;
    localparam logic signed [17:0] PLANE_X_RST = 18'sd0;
    localparam logic signed [17:0] PLANE_Y_RST = 18'sd43254;

    typedef struct packed {
        logic               func;
        logic [8:0]         column;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [3:0]         cell_value;
    } item_t;

    typedef struct packed {
        logic [8:0]         out_column;
        logic [4:0]         hit_x;
        logic [4:0]         hit_y;
        logic               hit_side;
        logic [23:0]        wall_distance;
        logic [8:0]         draw_start;
        logic [8:0]         draw_end;
        logic [2:0]         color_code;
        logic               cast_error;
    } result_t;

    typedef struct packed {
        logic [20:0]        pos_x;
        logic [20:0]        pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
    } cfg_t;

    // Classified command between front and back
    typedef struct packed {
        logic               is_cast;
        logic [8:0]         column;
        logic [ADDR_W-1:0]  addr;
        logic [3:0]         value;
    } cmd_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic               clearing;
    } back_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RAY_MUL,
        ST_RAY_SUM,
        ST_DDX_GO,
        ST_DDX_WAIT,
        ST_DDY_GO,
        ST_DDY_WAIT,
        ST_SIDE,
        ST_STEP,
        ST_TEST,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_HGT_GO,
        ST_HGT_WAIT,
        ST_ROWS,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/grc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module grc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/grc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module grc_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [grc_pkg::DIV_W-1:0]      dividend,
    input  wire logic [grc_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                busy,
    output logic      [grc_pkg::DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(grc_pkg::DIV_W);

    logic                              busy_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [grc_pkg::DIV_W-1:0]         quo_reg;
    logic [grc_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [grc_pkg::DIVISOR_W-1:0]     dvs_reg;
    logic [grc_pkg::DIVISOR_W:0]       trial;
    logic [grc_pkg::DIVISOR_W:0]       diff;
    logic                              qbit;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[grc_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(grc_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift dividend in, quotient bits out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[grc_pkg::DIV_W-2:0], qbit};
            rem_reg <= qbit ? diff[grc_pkg::DIVISOR_W-1:0]
                            : trial[grc_pkg::DIVISOR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/grc_front.sv =====
// Front end: takes input transfers, classifies them and queues commands.
// Depends on grc_pkg for the item and command types.
`timescale 1ns / 1ps
`default_nettype none

module grc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire grc_pkg::item_t      item,
    output logic                     full,
    input  wire grc_pkg::back_stat_t stat,
    input  wire logic                cmd_pop,
    output logic                     cmd_valid,
    output grc_pkg::cmd_t            cmd
);

    grc_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          accept;
    grc_pkg::cmd_t new_cmd;

    // Hold off input while the map is cleared or the queue is full
    assign full   = stat.clearing || (count_reg == 2'd2);
    assign accept = push && !full;

    // Classify the item into a map write or a cast
    always_comb
    begin
        new_cmd.is_cast = (item.func == grc_pkg::FUNC_CAST);
        new_cmd.column  = item.column;
        new_cmd.addr    = {item.cell_x, item.cell_y};
        new_cmd.value   = item.cell_value;
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, cmd_pop};
        end
    end

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== src/grc_back.sv =====
// Back end: map clearing and writes, ray setup, DDA walk, distance and rows.
// Depends on grc_pkg, grc_ram and grc_div.
`timescale 1ns / 1ps
`default_nettype none

module grc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire grc_pkg::cfg_t       cfg,
    input  wire logic                cmd_valid,
    input  wire grc_pkg::cmd_t       cmd,
    output logic                     cmd_pop,
    output grc_pkg::back_stat_t      stat,
    output logic                     empty,
    input  wire logic                pop,
    output grc_pkg::result_t         result
);

    localparam int AW = grc_pkg::ADDR_W;
    localparam logic [40:0] DELTA_INF = 41'h100_0000_0000;
    localparam logic [40:0] RECIP_NUM = 41'h001_0000_0000;
    localparam logic [grc_pkg::DIV_W-1:0] HGT_NUM =
        grc_pkg::DIV_W'(grc_pkg::SCREEN_HEIGHT) << grc_pkg::FRAC;

    grc_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]              clr_reg;
    logic [8:0]                 col_reg;
    logic signed [36:0]         prodx_reg, prody_reg;
    logic signed [20:0]         rdx_reg, rdy_reg;
    logic [40:0]                ddx_reg, ddy_reg;
    logic [47:0]                sdx_reg, sdy_reg;
    logic signed [6:0]          x_reg, y_reg;
    logic                       side_reg;
    logic [grc_pkg::STEP_W-1:0] cnt_reg;
    logic [3:0]                 cell_reg;
    logic                       fail_reg;
    logic [grc_pkg::DIST_W-1:0] dist_reg;
    logic [grc_pkg::LH_W-1:0]   lh_reg;
    logic [8:0]                 ds_reg, de_reg;
    grc_pkg::result_t           res_reg;
    logic                       out_valid_reg;

    // Datapath nets
    logic [18:0]                col_ext;
    logic signed [18:0]         camx;
    logic [20:0]                abs_rdx, abs_rdy;
    logic [16:0]                fac_x, fac_y;
    logic [49:0]                mulx, muly;
    logic [47:0]                sdx_init, sdy_init;
    logic                       take_x;
    logic signed [6:0]          x_next, y_next;
    logic                       oob;
    logic signed [24:0]         num;
    logic [23:0]                abs_num;
    logic [20:0]                abs_rd;
    logic [23:0]                half;
    logic                       out_free;
    grc_pkg::result_t           res_build;

    // RAM and divider hookup
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [3:0]                 ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [3:0]                 ram_rdata;
    logic                       div_start;
    logic [grc_pkg::DIV_W-1:0]  div_dividend;
    logic [grc_pkg::DIVISOR_W-1:0] div_divisor;
    logic                       div_busy;
    logic [grc_pkg::DIV_W-1:0]  div_quo;

    grc_ram #(
        .WIDTH (4),
        .DEPTH (grc_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Ray setup arithmetic
    always_comb
    begin
        col_ext = {10'b0, col_reg};
        camx    = $signed(col_ext << grc_pkg::CAMX_SHIFT) - 19'sd65536;
        abs_rdx = rdx_reg[20] ? 21'(-rdx_reg) : rdx_reg;
        abs_rdy = rdy_reg[20] ? 21'(-rdy_reg) : rdy_reg;
        fac_x   = rdx_reg[20] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
        fac_y   = rdy_reg[20] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};
        mulx    = fac_x * ddx_reg[32:0];
        muly    = fac_y * ddy_reg[32:0];
        sdx_init = ddx_reg[40] ? {7'b0, fac_x, 24'b0} : {14'b0, mulx[49:16]};
        sdy_init = ddy_reg[40] ? {7'b0, fac_y, 24'b0} : {14'b0, muly[49:16]};
    end

    // One DDA step: pick the nearer side and move across it
    always_comb
    begin
        take_x = (sdx_reg < sdy_reg);
        x_next = x_reg;
        y_next = y_reg;
        if (take_x)
        begin
            x_next = rdx_reg[20] ? x_reg - 7'sd1 : x_reg + 7'sd1;
        end
        else
        begin
            y_next = rdy_reg[20] ? y_reg - 7'sd1 : y_reg + 7'sd1;
        end
        oob = x_next[6] || (x_next >= 7'(grc_pkg::MAP_SIZE))
           || y_next[6] || (y_next >= 7'(grc_pkg::MAP_SIZE));
        ram_raddr = {x_next[grc_pkg::MAP_BITS-1:0], y_next[grc_pkg::MAP_BITS-1:0]};
    end

    // Distance numerator on the hit side
    always_comb
    begin
        if (!side_reg)
        begin
            num = {{2{x_reg[6]}}, x_reg, 16'b0} - {4'b0, cfg.pos_x}
                + (rdx_reg[20] ? 25'sd65536 : 25'sd0);
            abs_rd = abs_rdx;
        end
        else
        begin
            num = {{2{y_reg[6]}}, y_reg, 16'b0} - {4'b0, cfg.pos_y}
                + (rdy_reg[20] ? 25'sd65536 : 25'sd0);
            abs_rd = abs_rdy;
        end
        abs_num = num[24] ? 24'(-num) : num[23:0];
        half    = lh_reg[grc_pkg::LH_W-1:1];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grc_pkg::ST_CLEAR:
                if (clr_reg == {AW{1'b1}}) state_next = grc_pkg::ST_IDLE;
            grc_pkg::ST_IDLE:
                if (cmd_valid && cmd.is_cast) state_next = grc_pkg::ST_RAY_MUL;
            grc_pkg::ST_RAY_MUL:
                state_next = grc_pkg::ST_RAY_SUM;
            grc_pkg::ST_RAY_SUM:
                state_next = grc_pkg::ST_DDX_GO;
            grc_pkg::ST_DDX_GO:
                state_next = (rdx_reg == '0) ? grc_pkg::ST_DDY_GO : grc_pkg::ST_DDX_WAIT;
            grc_pkg::ST_DDX_WAIT:
                if (!div_busy) state_next = grc_pkg::ST_DDY_GO;
            grc_pkg::ST_DDY_GO:
                state_next = (rdy_reg == '0) ? grc_pkg::ST_SIDE : grc_pkg::ST_DDY_WAIT;
            grc_pkg::ST_DDY_WAIT:
                if (!div_busy) state_next = grc_pkg::ST_SIDE;
            grc_pkg::ST_SIDE:
                state_next = grc_pkg::ST_STEP;
            grc_pkg::ST_STEP:
                state_next = oob ? grc_pkg::ST_OUT : grc_pkg::ST_TEST;
            grc_pkg::ST_TEST:
                if (ram_rdata != 4'd0)
                    state_next = grc_pkg::ST_DIST_GO;
                else if (cnt_reg == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS))
                    state_next = grc_pkg::ST_OUT;
                else
                    state_next = grc_pkg::ST_STEP;
            grc_pkg::ST_DIST_GO:
                state_next = (abs_rd == '0) ? grc_pkg::ST_HGT_GO : grc_pkg::ST_DIST_WAIT;
            grc_pkg::ST_DIST_WAIT:
                if (!div_busy) state_next = grc_pkg::ST_HGT_GO;
            grc_pkg::ST_HGT_GO:
                state_next = (dist_reg == '0) ? grc_pkg::ST_ROWS : grc_pkg::ST_HGT_WAIT;
            grc_pkg::ST_HGT_WAIT:
                if (!div_busy) state_next = grc_pkg::ST_ROWS;
            grc_pkg::ST_ROWS:
                state_next = grc_pkg::ST_OUT;
            grc_pkg::ST_OUT:
                if (out_free) state_next = grc_pkg::ST_IDLE;
            default:
                state_next = grc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cmd.addr;
        ram_wdata    = cmd.value;
        div_start    = 1'b0;
        div_dividend = {1'b0, RECIP_NUM[38:0]};
        div_divisor  = {3'b0, abs_rdx};
        stat.clearing = 1'b0;
        unique case (state_reg)
            grc_pkg::ST_CLEAR:
            begin
                stat.clearing = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = clr_reg;
                ram_wdata     = 4'd0;
            end
            grc_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                ram_we  = cmd_valid && !cmd.is_cast;
            end
            grc_pkg::ST_DDX_GO:
                div_start = (rdx_reg != '0);
            grc_pkg::ST_DDY_GO:
            begin
                div_start   = (rdy_reg != '0);
                div_divisor = {3'b0, abs_rdy};
            end
            grc_pkg::ST_DIST_GO:
            begin
                div_start    = (abs_rd != '0);
                div_dividend = {abs_num, 16'b0};
                div_divisor  = {3'b0, abs_rd};
            end
            grc_pkg::ST_HGT_GO:
            begin
                div_start    = (dist_reg != '0);
                div_dividend = HGT_NUM;
                div_divisor  = dist_reg;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        out_free  = !out_valid_reg || pop;
        res_build = '0;
        res_build.out_column = col_reg;
        if (fail_reg)
        begin
            res_build.cast_error = 1'b1;
        end
        else
        begin
            res_build.hit_x         = x_reg[grc_pkg::MAP_BITS-1:0];
            res_build.hit_y         = y_reg[grc_pkg::MAP_BITS-1:0];
            res_build.hit_side      = side_reg;
            res_build.wall_distance = dist_reg;
            res_build.draw_start    = ds_reg;
            res_build.draw_end      = de_reg;
            res_build.color_code    = cell_reg[3] ? 3'd0 : cell_reg[2:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == grc_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == grc_pkg::ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            grc_pkg::ST_IDLE:
                col_reg <= cmd.column;
            grc_pkg::ST_RAY_MUL:
            begin
                prodx_reg <= cfg.plane_x * camx;
                prody_reg <= cfg.plane_y * camx;
                x_reg     <= {2'b0, cfg.pos_x[20:16]};
                y_reg     <= {2'b0, cfg.pos_y[20:16]};
                cnt_reg   <= '0;
                fail_reg  <= 1'b0;
                side_reg  <= 1'b0;
            end
            grc_pkg::ST_RAY_SUM:
            begin
                rdx_reg <= {{3{cfg.dir_x[17]}}, cfg.dir_x} + prodx_reg[36:16];
                rdy_reg <= {{3{cfg.dir_y[17]}}, cfg.dir_y} + prody_reg[36:16];
            end
            grc_pkg::ST_DDX_GO:
                ddx_reg <= DELTA_INF;
            grc_pkg::ST_DDX_WAIT:
                ddx_reg <= {1'b0, div_quo};
            grc_pkg::ST_DDY_GO:
                ddy_reg <= DELTA_INF;
            grc_pkg::ST_DDY_WAIT:
                ddy_reg <= {1'b0, div_quo};
            grc_pkg::ST_SIDE:
            begin
                sdx_reg <= sdx_init;
                sdy_reg <= sdy_init;
            end
            grc_pkg::ST_STEP:
            begin
                if (take_x)
                begin
                    sdx_reg <= sdx_reg + {7'b0, ddx_reg};
                end
                else
                begin
                    sdy_reg <= sdy_reg + {7'b0, ddy_reg};
                end
                x_reg    <= x_next;
                y_reg    <= y_next;
                side_reg <= !take_x;
                cnt_reg  <= cnt_reg + 1'b1;
                fail_reg <= oob;
            end
            grc_pkg::ST_TEST:
            begin
                cell_reg <= ram_rdata;
                fail_reg <= (ram_rdata == 4'd0);
            end
            grc_pkg::ST_DIST_GO:
                dist_reg <= {grc_pkg::DIST_W{1'b1}};
            grc_pkg::ST_DIST_WAIT:
                dist_reg <= (div_quo[39:24] != '0) ? {grc_pkg::DIST_W{1'b1}}
                                                   : div_quo[23:0];
            grc_pkg::ST_HGT_GO:
                lh_reg <= grc_pkg::LH_W'(4 * grc_pkg::SCREEN_HEIGHT);
            grc_pkg::ST_HGT_WAIT:
                lh_reg <= div_quo[grc_pkg::LH_W-1:0];
            grc_pkg::ST_ROWS:
            begin
                ds_reg <= (half >= 24'(grc_pkg::HALF_H)) ? 9'd0
                        : 9'(24'(grc_pkg::HALF_H) - half);
                de_reg <= (half >= 24'(grc_pkg::SCREEN_HEIGHT - grc_pkg::HALF_H))
                        ? 9'(grc_pkg::ROW_MAX) : 9'(half + 24'(grc_pkg::HALF_H));
            end
            grc_pkg::ST_OUT:
                if (out_free) res_reg <= res_build;
            default:
                cell_reg <= cell_reg;
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== src/grid_raycast_column.sv =====
// A cast runs ray setup and reciprocal division, then the grid walk, then
// distance and height division and output; the single shared divider and the
// walk, in which each grid step passes ST_STEP and then ST_TEST to read the
// map RAM, set how long it takes. Map writes are done in the idle state. One
// item at a time in the back end; two commands queue ahead of it.
// Reset: async active low; the map's 1024 cells are then cleared, full high.
`timescale 1ns / 1ps
`default_nettype none

module grid_raycast_column (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire grc_pkg::item_t             item,
    output logic                            full,
    output logic                            empty,
    input  wire logic                       pop,
    output grc_pkg::result_t                result,
    input  wire logic                       wr_en,
    input  wire logic [2:0]                 wr_index,
    input  wire logic [grc_pkg::CFG_W-1:0]  wr_data
);

    grc_pkg::cfg_t       cfg_reg;
    grc_pkg::back_stat_t stat;
    grc_pkg::cmd_t       cmd;
    logic                cmd_valid;
    logic                cmd_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= grc_pkg::POS_X_RST;
            cfg_reg.pos_y   <= grc_pkg::POS_Y_RST;
            cfg_reg.dir_x   <= grc_pkg::DIR_X_RST;
            cfg_reg.dir_y   <= grc_pkg::DIR_Y_RST;
            cfg_reg.plane_x <= grc_pkg::PLANE_X_RST;
            cfg_reg.plane_y <= grc_pkg::PLANE_Y_RST;
        end
        else if (wr_en)
        begin
            unique case (grc_pkg::cfg_idx_t'(wr_index))
                grc_pkg::CFG_POS_X:   cfg_reg.pos_x   <= wr_data;
                grc_pkg::CFG_POS_Y:   cfg_reg.pos_y   <= wr_data;
                grc_pkg::CFG_DIR_X:   cfg_reg.dir_x   <= wr_data[17:0];
                grc_pkg::CFG_DIR_Y:   cfg_reg.dir_y   <= wr_data[17:0];
                grc_pkg::CFG_PLANE_X: cfg_reg.plane_x <= wr_data[17:0];
                grc_pkg::CFG_PLANE_Y: cfg_reg.plane_y <= wr_data[17:0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    grc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .stat      (stat),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    grc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .stat      (stat),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/grc_check.sv =====
// Port-level checker for the ray caster, bound to the top level.
// Depends on grc_pkg and grid_raycast_column_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_raycast_column_defines.svh"

module grc_check (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire grc_pkg::result_t result
);

    // Hold a waiting result until it is taken
    `GRC_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(result), "result dropped or changed while stalled")

    // Failed casts carry only the column and the error flag
    `GRC_ASSERT_IMP(a_err_zero, !empty && result.cast_error, result.hit_x == 5'd0 && result.hit_y == 5'd0 && result.hit_side == 1'b0 && result.wall_distance == 24'd0 && result.draw_start == 9'd0 && result.draw_end == 9'd0 && result.color_code == 3'd0, "error result with nonzero fields")

    // Stripe rows stay ordered and on screen
    `GRC_ASSERT_IMP(a_rows, !empty && !result.cast_error, result.draw_start <= result.draw_end && result.draw_end <= 9'(grc_pkg::ROW_MAX), "stripe rows out of order")

    // Zero distance fills the whole column
    `GRC_ASSERT_IMP(a_zero_dist, !empty && !result.cast_error && result.wall_distance == 24'd0, result.draw_start == 9'd0 && result.draw_end == 9'(grc_pkg::ROW_MAX), "zero distance not full height")

endmodule

bind grid_raycast_column grc_check u_check (.*);

`default_nettype wire

// ===== sim/grid_raycast_column_tb.sv =====
// Testbench for the grid ray caster: map writes, column casts and view settings.
// Depends on grc_pkg and grid_raycast_column; all results are predicted in place.
`timescale 1ns / 1ps

module grid_raycast_column_tb;

    localparam longint QONE      = 64'sd65536;
    localparam longint DELTA_BIG = 64'sd1 << 40;
    localparam longint DIST_SAT  = 64'sd16777215;
    localparam int     SETTLE    = 300;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    grc_pkg::item_t              item;
    logic                        full;
    logic                        empty;
    logic                        pop;
    grc_pkg::result_t            result;
    logic                        wr_en;
    logic [2:0]                  wr_index;
    logic [grc_pkg::CFG_W-1:0]   wr_data;

    // Predictor state
    logic [3:0]                  grid [grc_pkg::MAP_DEPTH];
    logic [20:0]                 view_px, view_py;
    logic signed [17:0]          view_dx, view_dy, view_plx, view_ply;
    grc_pkg::result_t            pending_hits[$];
    int                          fail_count;
    int                          hold_cycles;
    bit                          long_hold;

    grid_raycast_column dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_q(longint v);
        if (v >= 0)
            return v >>> 16;
        return -((-v + QONE - 1) >>> 16);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Compute the expected result of one cast
    function automatic grc_pkg::result_t cast_column(logic [8:0] col);
        grc_pkg::result_t r;
        longint camx, rdx, rdy, px, py, x, y, fx, fy, ddx, ddy, sdx, sdy;
        longint num, rd, wdist, lh, ds, de;
        int stx, sty, side;
        bit hit;
        logic [grc_pkg::ADDR_W-1:0] gaddr;
        r = '0;
        r.out_column = col;
        gaddr = '0;
        camx = (longint'(col) * 2 * QONE) / grc_pkg::SCREEN_WIDTH - QONE;
        rdx = longint'(view_dx) + floor_q(longint'(view_plx) * camx);
        rdy = longint'(view_dy) + floor_q(longint'(view_ply) * camx);
        px = longint'(view_px);
        py = longint'(view_py);
        x = px >>> 16;
        y = py >>> 16;
        fx = px & (QONE - 1);
        fy = py & (QONE - 1);
        ddx = rdx == 0 ? DELTA_BIG : (64'sd1 << 32) / mag(rdx);
        ddy = rdy == 0 ? DELTA_BIG : (64'sd1 << 32) / mag(rdy);
        if (rdx < 0)
        begin
            stx = -1;
            sdx = (fx * ddx) >>> 16;
        end
        else
        begin
            stx = 1;
            sdx = ((QONE - fx) * ddx) >>> 16;
        end
        if (rdy < 0)
        begin
            sty = -1;
            sdy = (fy * ddy) >>> 16;
        end
        else
        begin
            sty = 1;
            sdy = ((QONE - fy) * ddy) >>> 16;
        end
        hit = 0;
        side = 0;
        for (int i = 0; i < grc_pkg::MAX_STEPS; i++)
        begin
            if (sdx < sdy)
            begin
                sdx += ddx;
                x += stx;
                side = 0;
            end
            else
            begin
                sdy += ddy;
                y += sty;
                side = 1;
            end
            if (x < 0 || x >= grc_pkg::MAP_SIZE || y < 0 || y >= grc_pkg::MAP_SIZE)
                break;
            gaddr = {x[grc_pkg::MAP_BITS-1:0], y[grc_pkg::MAP_BITS-1:0]};
            if (grid[gaddr] != 0)
            begin
                hit = 1;
                break;
            end
        end
        if (!hit)
        begin
            r.cast_error = 1'b1;
            return r;
        end
        if (side == 0)
        begin
            num = (x << 16) - px + (stx < 0 ? QONE : 0);
            rd = rdx;
        end
        else
        begin
            num = (y << 16) - py + (sty < 0 ? QONE : 0);
            rd = rdy;
        end
        if (rd == 0)
            wdist = DIST_SAT;
        else
        begin
            wdist = (mag(num) << 16) / mag(rd);
            if (wdist > DIST_SAT)
                wdist = DIST_SAT;
        end
        lh = wdist == 0 ? 4 * grc_pkg::SCREEN_HEIGHT
                        : (longint'(grc_pkg::SCREEN_HEIGHT) << 16) / wdist;
        ds = grc_pkg::HALF_H - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + grc_pkg::HALF_H;
        if (de >= grc_pkg::SCREEN_HEIGHT)
            de = grc_pkg::ROW_MAX;
        r.hit_x = x[4:0];
        r.hit_y = y[4:0];
        r.hit_side = side[0];
        r.wall_distance = wdist[23:0];
        r.draw_start = ds[8:0];
        r.draw_end = de[8:0];
        r.color_code = (grid[gaddr] inside {[1:7]}) ? grid[gaddr][2:0] : 3'd0;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one item and update the prediction on transfer; push stays high
    task automatic send_item(grc_pkg::item_t it);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        if (it.func == grc_pkg::FUNC_CAST)
            pending_hits.push_back(cast_column(it.column));
        else
            grid[{it.cell_x, it.cell_y}] = it.cell_value;
    endtask

    task automatic send_write(int cx, int cy, int v);
        grc_pkg::item_t it;
        it = '0;
        it.func = grc_pkg::FUNC_WRITE;
        it.cell_x = 5'(cx);
        it.cell_y = 5'(cy);
        it.cell_value = 4'(v);
        it.column = 9'($urandom);
        send_item(it);
    endtask

    task automatic send_cast(int col);
        grc_pkg::item_t it;
        it = '0;
        it.func = grc_pkg::FUNC_CAST;
        it.column = 9'(col);
        it.cell_x = 5'($urandom);
        it.cell_y = 5'($urandom);
        it.cell_value = 4'($urandom);
        send_item(it);
    endtask

    // Wait for idle, then write one register
    task automatic write_reg(grc_pkg::cfg_idx_t idx, logic [grc_pkg::CFG_W-1:0] value);
        push <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            grc_pkg::CFG_POS_X:   view_px = value;
            grc_pkg::CFG_POS_Y:   view_py = value;
            grc_pkg::CFG_DIR_X:   view_dx = value[17:0];
            grc_pkg::CFG_DIR_Y:   view_dy = value[17:0];
            grc_pkg::CFG_PLANE_X: view_plx = value[17:0];
            default:              view_ply = value[17:0];
        endcase
    endtask

    task automatic set_view(longint px, longint py, longint dx, longint dy,
                            longint plx, longint ply);
        write_reg(grc_pkg::CFG_POS_X, grc_pkg::CFG_W'(px));
        write_reg(grc_pkg::CFG_POS_Y, grc_pkg::CFG_W'(py));
        write_reg(grc_pkg::CFG_DIR_X, grc_pkg::CFG_W'(dx));
        write_reg(grc_pkg::CFG_DIR_Y, grc_pkg::CFG_W'(dy));
        write_reg(grc_pkg::CFG_PLANE_X, grc_pkg::CFG_W'(plx));
        write_reg(grc_pkg::CFG_PLANE_Y, grc_pkg::CFG_W'(ply));
    endtask

    task automatic build_room();
        for (int i = 0; i < grc_pkg::MAP_SIZE; i++)
        begin
            send_write(i, 0, 1 + (i % 15));
            send_write(i, grc_pkg::MAP_SIZE - 1, 1 + ((i + 3) % 15));
            send_write(0, i, 1 + ((i + 5) % 15));
            send_write(grc_pkg::MAP_SIZE - 1, i, 1 + ((i + 7) % 15));
        end
    endtask

    // Empty map, reset view, edge and middle columns: every ray leaves the map
    task automatic test_empty_map();
        send_cast(0);
        send_cast(grc_pkg::SCREEN_WIDTH - 1);
        send_cast(256);
        send_write(1, 1, 5);
        send_cast(100);
        send_write(1, 1, 0);
    endtask

    // Walls near the viewer, zero ray parts, zero distance, color codes
    task automatic test_directed();
        send_write(0, 1, 15);
        send_write(2, 1, 8);
        send_write(1, 0, 7);
        send_write(1, 2, 3);
        send_cast(0);
        send_cast(256);
        send_cast(511);
        set_view(QONE, 98304, 0, 65536, 0, 0);
        send_cast(0);
        send_cast(300);
        set_view(2097151, 2097151, -131072, -131072, 131071, -131072);
        send_cast(0);
        send_cast(511);
        set_view(QONE + 1, QONE + 1, 131071, 131071, 131071, 131071);
        send_cast(0);
        send_cast(511);
        build_room();
        set_view(16 * QONE + 1234, 16 * QONE + 77, 100, -65536, 43254, 0);
        for (int c = 0; c < 512; c += 73)
            send_cast(c);
    endtask

    // Random views and mixed traffic inside a walled room, then a fully random pass
    task automatic test_random();
        repeat (8)
        begin
            set_view($urandom_range(QONE, 31 * QONE - 1), $urandom_range(QONE, 31 * QONE - 1),
                     $urandom, $urandom, $urandom, $urandom);
            repeat (75)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_write($urandom_range(1, 30), $urandom_range(1, 30), $urandom);
                else
                    send_cast($urandom);
            end
        end
        // Fully random view and cells, borders included
        set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (60)
        begin
            if ($urandom_range(0, 1) == 0)
                send_write($urandom, $urandom, $urandom);
            else
                send_cast($urandom);
        end
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_backpressure();
        hold_cycles = 2000;
        long_hold = 1'b1;
        repeat (12) send_cast($urandom);
    endtask

    // Drain results and compare against the predicted ones
    initial
    begin
        grc_pkg::result_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_hits.size() == 0)
                begin
                    $error("unexpected result for column %0d", result.out_column);
                    fail_count++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (result !== want)
                    begin
                        fail_count++;
                        if (result.out_column !== want.out_column)
                            $error("out_column exp %0d got %0d", want.out_column, result.out_column);
                        if (result.hit_x !== want.hit_x)
                            $error("hit_x exp %0d got %0d", want.hit_x, result.hit_x);
                        if (result.hit_y !== want.hit_y)
                            $error("hit_y exp %0d got %0d", want.hit_y, result.hit_y);
                        if (result.hit_side !== want.hit_side)
                            $error("hit_side exp %0d got %0d", want.hit_side, result.hit_side);
                        if (result.wall_distance !== want.wall_distance)
                            $error("wall_distance exp %0d got %0d",
                                   want.wall_distance, result.wall_distance);
                        if (result.draw_start !== want.draw_start)
                            $error("draw_start exp %0d got %0d", want.draw_start, result.draw_start);
                        if (result.draw_end !== want.draw_end)
                            $error("draw_end exp %0d got %0d", want.draw_end, result.draw_end);
                        if (result.color_code !== want.color_code)
                            $error("color_code exp %0d got %0d", want.color_code, result.color_code);
                        if (result.cast_error !== want.cast_error)
                            $error("cast_error exp %0d got %0d", want.cast_error, result.cast_error);
                    end
                end
            end
            // Hold for a long stretch when asked, else stall at random
            if (long_hold)
            begin
                pop <= 1'b0;
                if (hold_cycles > 0)
                    hold_cycles--;
                else
                    long_hold = 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #20ms;
        $display("grid_raycast_column_tb failed");
        $finish;
    end

    initial
    begin
        fail_count = 0;
        long_hold = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        for (int i = 0; i < grc_pkg::MAP_DEPTH; i++)
            grid[i] = '0;
        view_px = grc_pkg::POS_X_RST;
        view_py = grc_pkg::POS_Y_RST;
        view_dx = grc_pkg::DIR_X_RST;
        view_dy = grc_pkg::DIR_Y_RST;
        view_plx = grc_pkg::PLANE_X_RST;
        view_ply = grc_pkg::PLANE_Y_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_map();
        test_directed();
        test_backpressure();
        test_random();

        push <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("grid_raycast_column_tb passed");
        else
            $display("grid_raycast_column_tb failed");
        $finish;
    end

endmodule
